// File: hdl/image_convolution_2d_top_defines.svh
// Assertion macros shared by the convolution block.
// Depends on a clk and rst in scope at the point of use.
`ifndef IMAGE_CONVOLUTION_2D_TOP_DEFINES_SVH
`define IMAGE_CONVOLUTION_2D_TOP_DEFINES_SVH

`define ICV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ICV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/icv_pkg.sv
// Types, constants and helpers of the 2D convolution block.
// No dependencies.
`timescale 1ns / 1ps
package icv_pkg;

  localparam int MAX_MASK     = 7;
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_CHANNELS = 4;
  localparam int COEF_FRAC    = 10;
  localparam int COEF_SLOTS   = MAX_MASK * MAX_MASK;
  localparam int RING_SIZE    = MAX_MASK * MAX_WIDTH * MAX_CHANNELS;
  localparam int RING_AW      = $clog2(RING_SIZE);
  localparam int SLOT_AW      = $clog2(COEF_SLOTS);
  localparam int PIX_MAX      = 255;

  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  localparam logic [2:0] REG_MASK_W = 3'd0;
  localparam logic [2:0] REG_MASK_H = 3'd1;
  localparam logic [2:0] REG_IMG_W  = 3'd2;
  localparam logic [2:0] REG_IMG_H  = 3'd3;
  localparam logic [2:0] REG_CHAN   = 3'd4;
  localparam logic [2:0] REG_FLIP   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_TAP,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic tap;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic last_tap;
    logic pipe_busy;
    logic slot_free;
  } dp_sts_t;

  typedef struct packed {
    logic [2:0]  w;
    logic [2:0]  h;
    logic [10:0] img_w;
    logic [15:0] img_h;
    logic [2:0]  chan;
    logic        flip;
  } cfg_t;

  function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] a,
                                                 input logic [RING_AW:0]   b);
    logic [RING_AW:0] s;
    s = {1'b0, a} + b;
    if (s >= (RING_AW+1)'(RING_SIZE)) s = s - (RING_AW+1)'(RING_SIZE);
    return s[RING_AW-1:0];
  endfunction

endpackage

// File: hdl/icv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module icv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/icv_ctrl.sv
// Sequencing state machine of the convolution block.
// Depends on icv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "image_convolution_2d_top_defines.svh"
module icv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  icv_pkg::dp_sts_t  sts,
  output icv_pkg::ctl_cmd_t cmd
);
  import icv_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && sts.emit_req) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_TAP;
      ST_TAP:   if (sts.last_tap) state_next = ST_DRAIN;
      ST_DRAIN: if (!sts.pipe_busy) state_next = ST_EMIT;
      ST_EMIT:  if (sts.slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    cmd.accept = (state == ST_IDLE) && in_valid;
    cmd.setup  = (state == ST_SETUP);
    cmd.tap    = (state == ST_TAP);
    cmd.emit   = (state == ST_EMIT) && sts.slot_free;
  end

  `ICV_ASSERT_NEXT(a_tap_end, state == ST_TAP && sts.last_tap, state == ST_DRAIN, "tap end")
  `ICV_ASSERT_NEXT(a_emit_done, cmd.emit, state == ST_IDLE, "emit not closed")
  `ICV_ASSERT_NEXT(a_start, cmd.accept && sts.emit_req, state == ST_SETUP, "no start")
endmodule

// File: hdl/icv_datapath.sv
// Datapath: position counters, line and coefficient memories, MAC and rounding.
// Depends on icv_pkg and icv_ram.
`timescale 1ns / 1ps
module icv_datapath (
  input  logic               clk,
  input  logic               rst,
  input  icv_pkg::cfg_t      cfg,
  input  logic               cfg_wr,
  input  icv_pkg::ctl_cmd_t  cmd,
  output icv_pkg::dp_sts_t   sts,
  input  logic [1:0]         command,
  input  logic [7:0]         sample,
  input  logic [5:0]         coef_index,
  input  logic signed [17:0] coef_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         result,
  output logic               last
);
  import icv_pkg::*;

  logic [12:0] wc;
  logic [15:0] lat, back;
  logic [RING_AW-1:0] wr_ptr, out_ptr, row_addr, tap_addr, start_addr;
  logic [9:0]  in_col, out_col;
  logic [15:0] in_row, out_row;
  logic [1:0]  in_ch, out_ch;
  logic        in_done;
  logic [15:0] cnt;
  logic [2:0]  m, n;
  logic signed [17:0] iy;
  logic signed [11:0] ix, ix0;
  logic [SLOT_AW-1:0] slot;
  logic        v1, inb1, pv, inb;
  logic [7:0]  pix_rd;
  logic signed [17:0] coef_rd;
  logic signed [26:0] prod;
  logic signed [31:0] acc;
  logic [32:0] rsum;
  logic [22:0] rval;
  logic [7:0]  rnd;
  logic        out_last, pix_wr, coef_wr;
  logic [5:0]  hw;

  assign wc   = {2'd0, cfg.img_w} * {10'd0, cfg.chan};
  assign lat  = 16'(({13'd0, cfg.h} - 16'd1 - 16'(cfg.h >> 1)) * wc)
              + 16'(({13'd0, cfg.w} - 16'd1 - 16'(cfg.w >> 1)) * cfg.chan);
  assign back = 16'(16'(cfg.h >> 1) * wc) + 16'(16'(cfg.w >> 1) * cfg.chan);
  assign hw   = {3'd0, cfg.h} * {3'd0, cfg.w};
  assign start_addr = ({1'b0, out_ptr} >= (RING_AW+1)'(back)) ?
                      RING_AW'({1'b0, out_ptr} - (RING_AW+1)'(back)) :
                      RING_AW'({1'b0, out_ptr} + (RING_AW+1)'(RING_SIZE)
                               - (RING_AW+1)'(back));

  assign pix_wr  = cmd.accept && command == CMD_PIXEL && !in_done;
  assign coef_wr = cmd.accept && command == CMD_COEF && coef_index < 6'(COEF_SLOTS);

  icv_ram #(.WIDTH(8), .DEPTH(RING_SIZE)) u_line (
    .clk(clk), .we(pix_wr), .waddr(wr_ptr), .wdata(sample),
    .raddr(tap_addr), .rdata(pix_rd));

  icv_ram #(.WIDTH(18), .DEPTH(COEF_SLOTS)) u_coef (
    .clk(clk), .we(coef_wr), .waddr(coef_index[SLOT_AW-1:0]), .wdata(coef_value),
    .raddr(slot), .rdata(coef_rd));

  assign inb = !iy[17] && (iy < $signed({2'b0, cfg.img_h}))
            && !ix[11] && (ix < $signed({1'b0, cfg.img_w}));

  assign out_last = ({1'b0, out_ch} + 3'd1 == cfg.chan)
                 && ({1'b0, out_col} + 11'd1 == cfg.img_w)
                 && ({1'b0, out_row} + 17'd1 == {1'b0, cfg.img_h});

  assign rsum = 33'($signed({acc[31], acc}) + 33'sd512);
  assign rval = rsum[32:COEF_FRAC];
  always_comb begin
    if (acc[31] || acc == 32'sd0) rnd = 8'd0;
    else if (rval > 23'(PIX_MAX)) rnd = 8'(PIX_MAX);
    else rnd = rval[7:0];
  end

  always_comb begin
    sts.emit_req  = (command == CMD_PIXEL && !in_done && cnt >= lat)
                 || ((command == CMD_PIXEL || command == CMD_DRAIN) && in_done);
    sts.last_tap  = ({1'b0, m} + 4'd1 == {1'b0, cfg.h}) && ({1'b0, n} + 4'd1 == {1'b0, cfg.w});
    sts.pipe_busy = v1 || pv;
    sts.slot_free = !out_valid || out_ready;
  end

  // input and output position tracking
  always_ff @(posedge clk) begin
    if (rst || cfg_wr || (cmd.emit && out_last)) begin
      in_col <= '0; in_row <= '0; in_ch <= '0; in_done <= 1'b0;
      out_col <= '0; out_row <= '0; out_ch <= '0;
      cnt <= '0; wr_ptr <= '0; out_ptr <= '0;
    end else if (pix_wr) begin
      wr_ptr <= ring_add(wr_ptr, (RING_AW+1)'(1));
      cnt <= cnt + 16'd1;
      if ({1'b0, in_ch} + 3'd1 >= cfg.chan) begin
        in_ch <= '0;
        if ({1'b0, in_col} + 11'd1 >= cfg.img_w) begin
          in_col <= '0;
          if ({1'b0, in_row} + 17'd1 >= {1'b0, cfg.img_h}) begin
            in_row <= '0;
            in_done <= 1'b1;
          end else in_row <= in_row + 16'd1;
        end else in_col <= in_col + 10'd1;
      end else in_ch <= in_ch + 2'd1;
    end else if (cmd.emit) begin
      out_ptr <= ring_add(out_ptr, (RING_AW+1)'(1));
      cnt <= cnt - 16'd1;
      if ({1'b0, out_ch} + 3'd1 >= cfg.chan) begin
        out_ch <= '0;
        if ({1'b0, out_col} + 11'd1 >= cfg.img_w) begin
          out_col <= '0;
          out_row <= out_row + 16'd1;
        end else out_col <= out_col + 10'd1;
      end else out_ch <= out_ch + 2'd1;
    end
  end

  // tap walk
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      m <= '0; n <= '0;
      iy <= $signed({2'b0, out_row}) - $signed({15'd0, cfg.h >> 1});
      ix0 <= $signed({2'b0, out_col}) - $signed({9'd0, cfg.w >> 1});
      ix <= $signed({2'b0, out_col}) - $signed({9'd0, cfg.w >> 1});
      row_addr <= start_addr;
      tap_addr <= start_addr;
      slot <= cfg.flip ? SLOT_AW'(hw - 6'd1) : '0;
    end else if (cmd.tap) begin
      slot <= cfg.flip ? slot - 1'b1 : slot + 1'b1;
      if ({1'b0, n} + 4'd1 == {1'b0, cfg.w}) begin
        n <= '0;
        m <= m + 3'd1;
        iy <= iy + 18'sd1;
        ix <= ix0;
        row_addr <= ring_add(row_addr, (RING_AW+1)'(wc));
        tap_addr <= ring_add(row_addr, (RING_AW+1)'(wc));
      end else begin
        n <= n + 3'd1;
        ix <= ix + 12'sd1;
        tap_addr <= ring_add(tap_addr, (RING_AW+1)'(cfg.chan));
      end
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      pv <= 1'b0;
    end else begin
      v1 <= cmd.tap;
      pv <= v1;
    end
    inb1 <= inb;
    prod <= (v1 && inb1) ? $signed({1'b0, pix_rd}) * coef_rd : 27'sd0;
    if (cmd.setup) acc <= '0;
    else if (pv) acc <= acc + 32'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.emit) begin
      result <= rnd;
      last <= out_last;
    end
  end
endmodule

// File: hdl/image_convolution_2d_top.sv
// Zero-padded 2D convolution of an interleaved 8-bit image, with APB registers.
// Depends on icv_pkg, icv_ctrl and icv_datapath.
// A coefficient word or a pixel word that yields no result is taken in the idle state.
// A word that yields a result goes through setup, tap, drain and emit: the window is walked
// one tap a cycle through the single read port of the line memory and one shared
// multiplier. The line memory (28672 x 8) is never read before it is written in a frame,
// so it needs no clearing after reset. Any register write restarts the frame.
`timescale 1ns / 1ps
module image_convolution_2d_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [7:0]         sample,
  input  logic [5:0]         coef_index,
  input  logic signed [17:0] coef_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         result,
  output logic               last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import icv_pkg::*;

  logic [2:0]  mask_width, mask_height, channels;
  logic [10:0] image_width;
  logic [15:0] image_height;
  logic        flip_mask;
  logic        wr, cfg_wr;
  logic [2:0]  idx;
  cfg_t        cfg;
  ctl_cmd_t    cmd;
  dp_sts_t     sts;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign cfg_wr = wr && (idx == REG_MASK_W || idx == REG_MASK_H || idx == REG_IMG_W
                      || idx == REG_IMG_H || idx == REG_CHAN || idx == REG_FLIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_width <= 3'd3; mask_height <= 3'd3;
      image_width <= 11'd640; image_height <= 16'd480;
      channels <= 3'd1; flip_mask <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_MASK_W: mask_width   <= pwdata[2:0];
        REG_MASK_H: mask_height  <= pwdata[2:0];
        REG_IMG_W:  image_width  <= pwdata[10:0];
        REG_IMG_H:  image_height <= pwdata[15:0];
        REG_CHAN:   channels     <= pwdata[2:0];
        REG_FLIP:   flip_mask    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MASK_W: prdata = {29'd0, mask_width};
      REG_MASK_H: prdata = {29'd0, mask_height};
      REG_IMG_W:  prdata = {21'd0, image_width};
      REG_IMG_H:  prdata = {16'd0, image_height};
      REG_CHAN:   prdata = {29'd0, channels};
      REG_FLIP:   prdata = {31'd0, flip_mask};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.w     = (mask_width == 3'd0) ? 3'd1 : mask_width;
    cfg.h     = (mask_height == 3'd0) ? 3'd1 : mask_height;
    cfg.img_w = (image_width == 11'd0) ? 11'd1 :
                (image_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width;
    cfg.img_h = (image_height == 16'd0) ? 16'd1 : image_height;
    cfg.chan  = (channels == 3'd0) ? 3'd1 :
                (channels > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : channels;
    cfg.flip  = flip_mask;
  end

  icv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd));

  icv_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cfg_wr(cfg_wr), .cmd(cmd), .sts(sts),
    .command(command), .sample(sample), .coef_index(coef_index),
    .coef_value(coef_value), .out_valid(out_valid), .out_ready(out_ready),
    .result(result), .last(last));
endmodule

// File: verif/image_convolution_2d_top_tb.sv
// Self-checking testbench for image_convolution_2d_top: random frames, masks and stalls.
// Predicts each filtered sample in a scoreboard class and checks it field by field.
// Depends on icv_pkg and the image_convolution_2d_top RTL.
`timescale 1ns / 1ps
module image_convolution_2d_top_tb;
  import icv_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [7:0] res;
    logic       lst;
  } pix_out_t;

  class conv_scoreboard;
    logic signed [17:0] coefs[COEF_SLOTS];
    logic [7:0]         ring[RING_SIZE];
    int unsigned        icol, irow, ich, ocol, orow, och;
    bit                 in_done;
    int unsigned        mw, mh, iw, ih, ch, fl;
    pix_out_t           pending_q[$];
    int                 errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      mw = 3; mh = 3; iw = 640; ih = 480; ch = 1; fl = 1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      icol = 0; irow = 0; ich = 0; ocol = 0; orow = 0; och = 0;
      in_done = 0;
    endfunction

    function int unsigned lim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void set_reg(logic [2:0] idx, int unsigned v);
      case (idx)
        REG_MASK_W: mw = v & 7;
        REG_MASK_H: mh = v & 7;
        REG_IMG_W:  iw = v & 16'h7ff;
        REG_IMG_H:  ih = v & 16'hffff;
        REG_CHAN:   ch = v & 7;
        REG_FLIP:   fl = v & 1;
        default: return;
      endcase
      restart();
    endfunction

    function logic [7:0] filter(int unsigned w, int unsigned h, int unsigned wd,
                                int unsigned ht, int unsigned c);
      longint sum, iy, ix, lin;
      int unsigned slot;
      sum = 0;
      for (int m = 0; m < h; m++) begin
        for (int n = 0; n < w; n++) begin
          iy = longint'(orow) + m - longint'(h / 2);
          ix = longint'(ocol) + n - longint'(w / 2);
          slot = fl ? (h - 1 - m) * w + (w - 1 - n) : m * w + n;
          if (iy < 0 || iy >= ht || ix < 0 || ix >= wd) continue;
          lin = ((iy * wd + ix) * c + och) % RING_SIZE;
          sum += longint'({1'b0, ring[lin]}) * longint'(coefs[slot]);
        end
      end
      if (sum <= 0) return 8'd0;
      sum = (sum + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
      return (sum > PIX_MAX) ? 8'(PIX_MAX) : sum[7:0];
    endfunction

    function void emit(int unsigned w, int unsigned h, int unsigned wd,
                       int unsigned ht, int unsigned c);
      pix_out_t e;
      e.lst = (och + 1 == c) && (ocol + 1 == wd) && (orow + 1 == ht);
      e.res = filter(w, h, wd, ht, c);
      pending_q.push_back(e);
      och++;
      if (och >= c) begin
        och = 0;
        ocol++;
        if (ocol >= wd) begin
          ocol = 0;
          orow++;
          if (orow >= ht) orow = 0;
        end
      end
      if (e.lst) restart();
    endfunction

    function void note_word(logic [1:0] cmd, logic [7:0] smp, logic [5:0] idx,
                            logic signed [17:0] val);
      int unsigned w, h, wd, ht, c;
      longint lin_in, lin_out, lat;
      w = lim(mw, MAX_MASK); h = lim(mh, MAX_MASK);
      wd = lim(iw, MAX_WIDTH); ht = lim(ih, 65535); c = lim(ch, MAX_CHANNELS);
      if (cmd == CMD_COEF) begin
        if (idx < COEF_SLOTS) coefs[idx] = val;
      end else if (cmd == CMD_PIXEL && !in_done) begin
        lin_in = (longint'(irow) * wd + icol) * c + ich;
        lin_out = (longint'(orow) * wd + ocol) * c + och;
        lat = longint'(h - 1 - h / 2) * wd * c + longint'(w - 1 - w / 2) * c;
        ring[lin_in % RING_SIZE] = smp;
        ich++;
        if (ich >= c) begin
          ich = 0;
          icol++;
          if (icol >= wd) begin
            icol = 0;
            irow++;
            if (irow >= ht) begin
              irow = 0;
              in_done = 1;
            end
          end
        end
        if (lin_out + lat <= lin_in) emit(w, h, wd, ht, c);
      end else if ((cmd == CMD_PIXEL || cmd == CMD_DRAIN) && in_done) begin
        emit(w, h, wd, ht, c);
      end
    endfunction

    function void check_word(logic [7:0] res, logic lst);
      pix_out_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected word: result %0d last %0d", res, lst);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (res !== e.res) begin
        $error("result: expected %0d actual %0d", e.res, res);
        errors++;
      end
      if (lst !== e.lst) begin
        $error("last: expected %0d actual %0d", e.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         command = '0;
  logic [7:0]         sample = '0;
  logic [5:0]         coef_index = '0;
  logic signed [17:0] coef_value = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [7:0]         result;
  logic               last;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  conv_scoreboard sb = new();
  int  accepted = 0;
  bit  calm = 0;
  bit  held = 0;

  image_convolution_2d_top uut (.*);

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [17:0] pick_coef();
    if ($urandom_range(0, 4) == 0) return 18'($urandom);
    return 18'($signed($urandom_range(0, 1000)) - 300);
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [7:0] smp, logic [5:0] idx,
                           logic signed [17:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd; sample <= smp; coef_index <= idx; coef_value <= val;
    do @(posedge clk); while (!in_ready);
    sb.note_word(cmd, smp, idx, val);
    accepted++;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_word(CMD_COEF, 8'($urandom), 6'($urandom_range(0, COEF_SLOTS - 1)),
                   pick_coef());
      1: send_word(CMD_COEF, 8'($urandom), 6'($urandom_range(COEF_SLOTS, 63)),
                   18'($urandom));
      2: send_word(CMD_NONE, 8'($urandom), 6'($urandom), 18'($urandom));
      default: send_word(CMD_DRAIN, 8'($urandom), 6'($urandom), 18'($urandom));
    endcase
  endtask

  task automatic settle();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int unsigned v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic run_frames(int unsigned mw, int unsigned mh, int unsigned iw,
                            int unsigned ih, int unsigned c, int unsigned fl,
                            int nsamp, int frames);
    settle();
    reg_write(REG_MASK_W, mw);
    reg_write(REG_MASK_H, mh);
    reg_write(REG_IMG_W, iw);
    reg_write(REG_IMG_H, ih);
    reg_write(REG_CHAN, c);
    reg_write(REG_FLIP, fl);
    repeat (frames) begin
      for (int i = 0; i < nsamp; i++) begin
        if ($urandom_range(0, 19) == 0) send_noise();
        send_word(CMD_PIXEL, 8'($urandom_range(0, 255)), 6'($urandom), 18'($urandom));
      end
      while (sb.in_done)
        send_word($urandom_range(0, 5) == 0 ? CMD_PIXEL : CMD_DRAIN,
                  8'($urandom), 6'($urandom), 18'($urandom));
    end
  endtask

  initial begin
    #2000000;
    $display("image_convolution_2d_top test failed");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_word(result, last);
      if (!held && accepted >= 300) begin
        held = 1;
        out_ready <= 0;
        repeat (500) @(posedge clk);
      end
      if (!calm && $urandom_range(0, 49) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) < 70 ||
                                    $urandom_range(0, 9) == 0 ? 1'b1 : 1'b0);
      end
    end
  end

  initial begin
    int unsigned w, h, wd, ht, c;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_word(CMD_COEF, 8'hff, 6'd0, -18'sd131072);
    send_word(CMD_COEF, 8'h00, 6'd1, 18'sd131071);
    for (int i = 2; i < COEF_SLOTS; i++) send_word(CMD_COEF, 8'($urandom), 6'(i), pick_coef());
    send_word(CMD_COEF, 8'($urandom), 6'd63, 18'($urandom));
    send_word(CMD_NONE, 8'($urandom), 6'($urandom), 18'($urandom));
    send_word(CMD_DRAIN, 8'($urandom), 6'($urandom), 18'($urandom));
    send_word(CMD_PIXEL, 8'd0, '0, '0);
    send_word(CMD_PIXEL, 8'd255, '1, '1);
    run_frames(1, 1, 1, 1, 1, 0, 1, 2);
    run_frames(0, 0, 0, 0, 0, 1, 1, 1);
    run_frames(7, 7, 3, 4, 2, 1, 24, 1);
    run_frames(7, 1, 2047, 65535, 7, 0, 40, 1);
    run_frames(3, 7, 1024, 2, 4, 1, 30, 1);
    for (int p = 0; accepted < 750; p++) begin
      calm = (p % 4 == 3);
      w = $urandom_range(1, 7); h = $urandom_range(1, 7);
      wd = $urandom_range(1, 8); ht = $urandom_range(1, 5); c = $urandom_range(1, 4);
      if (p % 6 == 5)
        run_frames(w, h, wd, ht + 2, c, $urandom_range(0, 1), $urandom_range(1, wd * c), 1);
      else
        run_frames(w, h, wd, ht, c, $urandom_range(0, 1), wd * ht * c,
                   $urandom_range(1, 2));
    end
    calm = 0;
    settle();
    if (sb.errors == 0) begin
      $display("image_convolution_2d_top test passed");
    end else begin
      $display("image_convolution_2d_top test failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/icv_pkg.sv
hdl/icv_ram.sv
hdl/icv_ctrl.sv
hdl/icv_datapath.sv
hdl/image_convolution_2d_top.sv
verif/image_convolution_2d_top_tb.sv
